>>> rtl/core/ttempo_pkg.sv
package ttempo_pkg;

  // history depth; every slot, count and divisor width follows from it (2..16)
  localparam int MAX_TAPS = 8;
  localparam int SLOT_W   = $clog2(MAX_TAPS);
  localparam int COUNT_W  = $clog2(MAX_TAPS + 1);

  localparam int DATA_W   = 32;
  localparam int HELD_W   = 4;
  localparam int ITER_W   = $clog2(DATA_W);

  // register file
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_P_FLOOR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_P_CEILING = 2'd3;

  localparam logic [DATA_W-1:0] MIN_GAP_RST   = 32'd150000;
  localparam logic [DATA_W-1:0] MAX_GAP_RST   = 32'd2500000;
  localparam logic [DATA_W-1:0] P_FLOOR_RST   = 32'd10000;
  localparam logic [DATA_W-1:0] P_CEILING_RST = 32'd2000000;

  typedef struct packed {
    logic                start;
    logic [DATA_W-1:0]   dividend;
    logic [COUNT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DATA_W-1:0]   quotient;
  } div_rsp_t;

  // tap count as reported: low four bits, zero-extended when narrower
  function automatic logic [HELD_W-1:0] held_field(input logic [COUNT_W-1:0] cnt);
    logic [COUNT_W+HELD_W-1:0] ext;
    ext = {{HELD_W{1'b0}}, cnt};
    return ext[HELD_W-1:0];
  endfunction

  // next slot around the ring
  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] res;
    if (slot == SLOT_W'(MAX_TAPS - 1)) begin
      res = '0;
    end else begin
      res = slot + 1'b1;
    end
    return res;
  endfunction

endpackage

>>> rtl/core/tap_tempo_estimator.sv
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+------------------------------------
// tap      | in        | in_valid/in_stall  | tap_time_us[31:0]
// result   | out       | out_valid/out_stall| period_valid, period_us[31:0],
//          |           |                    | taps_held[3:0]
// config   | in        | cfg_write          | cfg_index[1:0], cfg_data[31:0]
//
// A tap request steps through the gap, decide, update and read states, then
// span, the bit-serial divider (32 quotient bits, then a done flag), clamp
// and the load in finish. With fewer than two taps the span, divide and
// clamp states are skipped. With a free output the next tap can be taken in
// the cycle after the load.
// in_stall is high from acceptance until the result is loaded into the output
// register; a held result does not block the next tap request.
// rst is synchronous and restores the register defaults and an empty history.
module tap_tempo_estimator (
  input  logic                               clk,
  input  logic                               rst,
  // tap channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ttempo_pkg::DATA_W-1:0]      tap_time_us,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               period_valid,
  output logic [ttempo_pkg::DATA_W-1:0]      period_us,
  output logic [ttempo_pkg::HELD_W-1:0]      taps_held,
  // register writes
  input  logic                               cfg_write,
  input  logic [ttempo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ttempo_pkg::DATA_W-1:0]      cfg_data
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_GAP    = 9'b000000010,
    ST_DECIDE = 9'b000000100,
    ST_UPDATE = 9'b000001000,
    ST_READ   = 9'b000010000,
    ST_SPAN   = 9'b000100000,
    ST_DIVIDE = 9'b001000000,
    ST_CLAMP  = 9'b010000000,
    ST_FINISH = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration registers
  logic [ttempo_pkg::DATA_W-1:0] min_gap;
  logic [ttempo_pkg::DATA_W-1:0] max_gap;
  logic [ttempo_pkg::DATA_W-1:0] p_floor;
  logic [ttempo_pkg::DATA_W-1:0] p_ceiling;

  // tap history: ring of timestamps plus pointers
  logic [ttempo_pkg::DATA_W-1:0]  tap_mem [ttempo_pkg::MAX_TAPS];
  logic [ttempo_pkg::COUNT_W-1:0] tap_count;
  logic [ttempo_pkg::SLOT_W-1:0]  newest_slot;
  logic [ttempo_pkg::SLOT_W-1:0]  oldest_slot;
  logic [ttempo_pkg::DATA_W-1:0]  newest_time;   // copy of the newest slot

  // per-request working registers
  logic [ttempo_pkg::DATA_W-1:0]  now_time;
  logic [ttempo_pkg::DATA_W-1:0]  gap;
  logic                           extend;
  logic [ttempo_pkg::DATA_W-1:0]  oldest_time;
  logic [ttempo_pkg::DATA_W-1:0]  period;
  logic                           result_valid;

  logic [ttempo_pkg::SLOT_W-1:0]  wr_slot;
  logic                           out_free;

  ttempo_pkg::div_req_t div_req;
  ttempo_pkg::div_rsp_t div_rsp;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // slot written by this tap: next in ring on a run, slot zero on restart
  assign wr_slot = extend ? ttempo_pkg::slot_inc(newest_slot) : '0;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap   <= ttempo_pkg::MIN_GAP_RST;
      max_gap   <= ttempo_pkg::MAX_GAP_RST;
      p_floor   <= ttempo_pkg::P_FLOOR_RST;
      p_ceiling <= ttempo_pkg::P_CEILING_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        ttempo_pkg::REG_MIN_GAP:   min_gap   <= cfg_data;
        ttempo_pkg::REG_MAX_GAP:   max_gap   <= cfg_data;
        ttempo_pkg::REG_P_FLOOR:   p_floor   <= cfg_data;
        ttempo_pkg::REG_P_CEILING: p_ceiling <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_GAP;
      ST_GAP:    state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_READ;
      ST_READ:   state_next = (tap_count >= ttempo_pkg::COUNT_W'(2)) ? ST_SPAN : ST_FINISH;
      ST_SPAN:   state_next = ST_DIVIDE;
      ST_DIVIDE: if (div_rsp.done) state_next = ST_CLAMP;
      ST_CLAMP:  state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // history pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count   <= '0;
      newest_slot <= '0;
      oldest_slot <= '0;
    end else if (state == ST_UPDATE) begin
      newest_slot <= wr_slot;
      if (!extend) begin
        tap_count   <= ttempo_pkg::COUNT_W'(1);
        oldest_slot <= '0;
      end else if (tap_count < ttempo_pkg::COUNT_W'(ttempo_pkg::MAX_TAPS)) begin
        tap_count <= tap_count + 1'b1;
      end else begin
        // full ring: the new tap overwrote the oldest slot
        oldest_slot <= ttempo_pkg::slot_inc(oldest_slot);
      end
    end
  end

  // timestamp ring, one write and one registered read
  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      tap_mem[wr_slot] <= now_time;
    end
    if (state == ST_READ) begin
      oldest_time <= tap_mem[oldest_slot];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) now_time <= tap_time_us;
      end
      ST_GAP: begin
        gap <= now_time - newest_time;   // wraps mod 2^32
      end
      ST_DECIDE: begin
        extend <= (tap_count != '0) && (gap > min_gap) && (gap < max_gap);
      end
      ST_UPDATE: begin
        newest_time <= now_time;
      end
      ST_READ: begin
        period       <= '0;
        result_valid <= 1'b0;
      end
      ST_DIVIDE: begin
        if (div_rsp.done) period <= div_rsp.quotient;
      end
      ST_CLAMP: begin
        // floor is checked first, so with floor above ceiling any period at or above the floor gets the ceiling
        if (period < p_floor) begin
          period <= p_floor;
        end else if (period > p_ceiling) begin
          period <= p_ceiling;
        end
        result_valid <= 1'b1;
      end
      default: ;
    endcase
  end

  // span over the run divided by the number of intervals
  always_comb begin
    div_req.start    = (state == ST_SPAN);
    div_req.dividend = now_time - oldest_time;
    div_req.divisor  = tap_count - 1'b1;
  end

  ttempo_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      period_valid <= result_valid;
      period_us    <= period;
      taps_held    <= ttempo_pkg::held_field(tap_count);
    end
  end

endmodule

>>> rtl/core/ttempo_div.sv
// restoring divider, one quotient bit per cycle
module ttempo_div (
  input  logic                  clk,
  input  logic                  rst,
  input  ttempo_pkg::div_req_t  req,
  output ttempo_pkg::div_rsp_t  rsp
);

  logic                               busy;
  logic                               done;
  logic [ttempo_pkg::ITER_W-1:0]      iter;
  logic [ttempo_pkg::COUNT_W-1:0]     rem;
  logic [ttempo_pkg::COUNT_W-1:0]     divisor;
  logic [ttempo_pkg::DATA_W-1:0]      quot;
  logic [ttempo_pkg::COUNT_W:0]       rem_sh;
  logic [ttempo_pkg::COUNT_W:0]       rem_sub;
  logic                               fits;

  assign rem_sh  = {rem, quot[ttempo_pkg::DATA_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign fits    = (rem_sh >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        iter <= iter + 1'b1;
        if (iter == ttempo_pkg::ITER_W'(ttempo_pkg::DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quot    <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      if (fits) begin
        rem  <= rem_sub[ttempo_pkg::COUNT_W-1:0];
        quot <= {quot[ttempo_pkg::DATA_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[ttempo_pkg::COUNT_W-1:0];
        quot <= {quot[ttempo_pkg::DATA_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quot;

endmodule

>>> tb/sv/testbench.sv
module testbench;

  // one result request as seen on the output channel
  typedef struct packed {
    logic                          valid;
    logic [ttempo_pkg::DATA_W-1:0] period;
    logic [ttempo_pkg::HELD_W-1:0] held;
  } tempo_t;

  // opening rows: timestamp, whether the result is typed in, and that result
  typedef struct {
    logic [ttempo_pkg::DATA_W-1:0] stamp;
    bit                            known;
    tempo_t                        want;
  } opening_row_t;

  localparam int SETTLE_CYCLES = 48;
  localparam int LONG_HOLD     = 300;     // receiver back-pressure stretch
  localparam int TIMEOUT       = 10_000_000;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             in_valid;
  logic                             in_stall;
  logic [ttempo_pkg::DATA_W-1:0]    tap_time_us;
  logic                             out_valid;
  logic                             out_stall;
  logic                             period_valid;
  logic [ttempo_pkg::DATA_W-1:0]    period_us;
  logic [ttempo_pkg::HELD_W-1:0]    taps_held;
  logic                             cfg_write;
  logic [ttempo_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ttempo_pkg::DATA_W-1:0]    cfg_data;

  tap_tempo_estimator uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .tap_time_us  (tap_time_us),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .period_valid (period_valid),
    .period_us    (period_us),
    .taps_held    (taps_held),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Tempo predictor: own copy of the register file and the tap history.
  // ---------------------------------------------------------------------------
  logic [ttempo_pkg::DATA_W-1:0] cur_min_gap, cur_max_gap, cur_floor, cur_ceiling;
  logic [ttempo_pkg::DATA_W-1:0] run_times [ttempo_pkg::MAX_TAPS];
  int unsigned       run_len;     // taps held in the current run
  int unsigned       run_head;    // slot of the newest tap

  tempo_t due_periods [$];        // results still owed by the block, oldest first
  int     mismatches = 0;
  bit     hold_results = 1'b0;    // asks the result side for one long stall
  bit     tx_busy = 1'b1;         // sender inserts gaps when set

  function automatic void reset_tempo_model();
    cur_min_gap = ttempo_pkg::MIN_GAP_RST;
    cur_max_gap = ttempo_pkg::MAX_GAP_RST;
    cur_floor   = ttempo_pkg::P_FLOOR_RST;
    cur_ceiling = ttempo_pkg::P_CEILING_RST;
    foreach (run_times[i]) run_times[i] = '0;
    run_len  = 0;
    run_head = 0;
  endfunction

  // Tap joins the run only when the wrapped gap lies strictly inside the
  // window; otherwise the history restarts in slot zero with this tap alone.
  function automatic tempo_t predict_tap(input logic [ttempo_pkg::DATA_W-1:0] now);
    logic [ttempo_pkg::DATA_W-1:0] gap, span, avg;
    int unsigned       oldest;
    bit                joins;
    tempo_t            r;
    joins = 1'b0;
    if (run_len > 0) begin
      gap   = now - run_times[run_head];
      joins = (gap > cur_min_gap) && (gap < cur_max_gap);
    end
    if (joins) begin
      run_head = (run_head + 1) % ttempo_pkg::MAX_TAPS;
      run_times[run_head] = now;
      if (run_len < ttempo_pkg::MAX_TAPS) run_len++;
    end else begin
      run_head = 0;
      run_times[0] = now;
      run_len = 1;
    end
    r = '0;
    r.held = ttempo_pkg::HELD_W'(run_len);
    if (run_len >= 2) begin
      oldest = (run_head + ttempo_pkg::MAX_TAPS - (run_len - 1)) % ttempo_pkg::MAX_TAPS;
      span   = run_times[run_head] - run_times[oldest];
      avg    = span / ttempo_pkg::DATA_W'(run_len - 1);
      // floor is checked first, so with floor above ceiling any period at or above the floor gets the ceiling
      if (avg < cur_floor) avg = cur_floor;
      else if (avg > cur_ceiling) avg = cur_ceiling;
      r.valid  = 1'b1;
      r.period = avg;
    end
    return r;
  endfunction

  // Gap to the next tap: mostly inside the join window, some exactly on its
  // edges, some repeated timestamps and some arbitrary jumps.
  function automatic logic [ttempo_pkg::DATA_W-1:0] pick_gap();
    longint unsigned lo, hi, width;
    int unsigned     r;
    lo = cur_min_gap;
    hi = cur_max_gap;
    r  = $urandom_range(0, 99);
    if (r < 78 && hi > lo + 1) begin
      width = hi - lo - 1;
      return ttempo_pkg::DATA_W'(lo + 1 + ({$urandom, $urandom} % width));
    end
    if (r < 84) return cur_min_gap;
    if (r < 90) return cur_max_gap;
    if (r < 93) return '0;
    if (r < 96) return cur_min_gap + 1;
    return $urandom;
  endfunction

  // mostly short idles, a few long ones; none at all when not busy
  function automatic int unsigned idle_len(input bit busy);
    int unsigned r;
    if (!busy) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Tap side
  // ---------------------------------------------------------------------------
  task automatic offer_tap(input logic [ttempo_pkg::DATA_W-1:0] stamp, input bit known,
                           input tempo_t typed);
    tempo_t want;
    in_valid    <= 1'b1;
    tap_time_us <= stamp;
    do @(posedge clk); while (in_stall !== 1'b0);
    want = predict_tap(stamp);
    due_periods.insert(due_periods.size(), known ? typed : want);
  endtask

  task automatic tap_gap();
    int unsigned n;
    n = idle_len(tx_busy);
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // wait for every owed result, then let the block settle
  task automatic drain_results();
    do @(posedge clk); while (due_periods.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // all four registers, back to back; only called with the block idle
  task automatic load_regs(input logic [ttempo_pkg::DATA_W-1:0] mn, mx, fl, cl);
    cfg_write <= 1'b1;
    cfg_index <= ttempo_pkg::REG_MIN_GAP;
    cfg_data  <= mn;
    @(posedge clk);
    cfg_index <= ttempo_pkg::REG_MAX_GAP;
    cfg_data  <= mx;
    @(posedge clk);
    cfg_index <= ttempo_pkg::REG_P_FLOOR;
    cfg_data  <= fl;
    @(posedge clk);
    cfg_index <= ttempo_pkg::REG_P_CEILING;
    cfg_data  <= cl;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_min_gap = mn;
    cur_max_gap = mx;
    cur_floor   = fl;
    cur_ceiling = cl;
  endtask

  // One phase of random taps. With pressure, the result side is held off
  // while taps keep coming, and later the sender waits for a full drain.
  task automatic tap_phase(input int unsigned n_items, input bit pressure);
    logic [ttempo_pkg::DATA_W-1:0] now;
    int unsigned       k;
    // start near the top of the counter now and then so runs wrap
    now = ($urandom_range(0, 2) == 0) ? 32'hFFF0_0000 + $urandom_range(0, 65535)
                                      : $urandom;
    for (k = 0; k < n_items; k++) begin
      if (k % 40 == 0) tx_busy = ($urandom_range(0, 3) != 0);
      if (pressure && k == 50) begin
        hold_results = 1'b1;
        tx_busy = 1'b0;
      end
      if (pressure && k == 120) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (due_periods.size() != 0);
      end
      now = now + pick_gap();
      offer_tap(now, 1'b0, '0);
      tap_gap();
    end
    in_valid <= 1'b0;
  endtask

  // Opening rows under reset registers (window 150000..2500000, clamp
  // 10000..2000000): window edges, wrap through zero, ceiling clamp, repeated
  // timestamp, history overflow past eight taps, and both timestamp extremes.
  opening_row_t opening [25] = '{
    '{32'd0,          1, '{1'b0, 32'd0,       4'd1}},
    '{32'd500000,     1, '{1'b1, 32'd500000,  4'd2}},
    '{32'd1000000,    1, '{1'b1, 32'd500000,  4'd3}},
    '{32'd1150000,    1, '{1'b0, 32'd0,       4'd1}},  // gap equals min
    '{32'd3650000,    1, '{1'b0, 32'd0,       4'd1}},  // gap equals max
    '{32'd3800001,    1, '{1'b1, 32'd150001,  4'd2}},
    '{32'd6300000,    1, '{1'b1, 32'd1325000, 4'd3}},
    '{32'hFFFF_FF00,  1, '{1'b0, 32'd0,       4'd1}},
    '{32'h0004_92E0,  1, '{1'b1, 32'd300000,  4'd2}},  // wraps through zero
    '{32'd2699744,    1, '{1'b1, 32'd1350000, 4'd3}},
    '{32'd100000000,  1, '{1'b0, 32'd0,       4'd1}},
    '{32'd102400000,  1, '{1'b1, 32'd2000000, 4'd2}},  // ceiling clamp
    '{32'd102400000,  1, '{1'b0, 32'd0,       4'd1}},  // same timestamp
    '{32'd102600000,  1, '{1'b1, 32'd200000,  4'd2}},
    '{32'd102800000,  1, '{1'b1, 32'd200000,  4'd3}},
    '{32'd103000000,  1, '{1'b1, 32'd200000,  4'd4}},
    '{32'd103200000,  1, '{1'b1, 32'd200000,  4'd5}},
    '{32'd103400000,  1, '{1'b1, 32'd200000,  4'd6}},
    '{32'd103600000,  1, '{1'b1, 32'd200000,  4'd7}},
    '{32'd103800000,  1, '{1'b1, 32'd200000,  4'd8}},
    '{32'd104000000,  1, '{1'b1, 32'd200000,  4'd8}},  // oldest dropped
    '{32'd104200000,  1, '{1'b1, 32'd200000,  4'd8}},
    '{32'd106699999,  0, '{1'b0, 32'd0,       4'd0}},
    '{32'hFFFF_FFFF,  1, '{1'b0, 32'd0,       4'd1}},
    '{32'd200000,     1, '{1'b1, 32'd200001,  4'd2}}
  };

  initial begin : stimulus
    int unsigned       i;
    logic [ttempo_pkg::DATA_W-1:0] mn, mx, fl, cl;
    rst         = 1'b1;
    in_valid    = 1'b0;
    tap_time_us = '0;
    cfg_write   = 1'b0;
    cfg_index   = ttempo_pkg::REG_MIN_GAP;
    cfg_data    = '0;
    reset_tempo_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < $size(opening); i++) begin
      offer_tap(opening[i].stamp, opening[i].known, opening[i].want);
      tap_gap();
    end
    in_valid <= 1'b0;
    drain_results();

    // reset registers, with the back-pressure stretch and a full pause
    tap_phase(200, 1'b1);
    drain_results();
    // everything but gap 0 and all-ones joins; no clamping
    load_regs(32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    tap_phase(150, 1'b0);
    drain_results();
    // narrow window, both clamps active
    load_regs(32'd1000, 32'd5000, 32'd1500, 32'd3000);
    tap_phase(200, 1'b0);
    drain_results();
    // nothing can join
    load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    tap_phase(40, 1'b0);
    drain_results();
    // floor above ceiling at the extremes: every valid period reads all ones
    load_regs(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    tap_phase(60, 1'b0);
    drain_results();
    // floor above ceiling with ordinary tap gaps
    load_regs(ttempo_pkg::MIN_GAP_RST, ttempo_pkg::MAX_GAP_RST, 32'd900000, 32'd300000);
    tap_phase(150, 1'b0);
    drain_results();
    // zero-width window
    load_regs(32'd0, 32'd0, ttempo_pkg::P_FLOOR_RST, ttempo_pkg::P_CEILING_RST);
    tap_phase(30, 1'b0);
    drain_results();
    // random settings
    mn = $urandom_range(0, 400000);
    mx = mn + $urandom_range(2, 3000000);
    fl = $urandom_range(0, 300000);
    cl = fl + $urandom_range(0, 2000000);
    load_regs(mn, mx, fl, cl);
    tap_phase(150, 1'b0);
    drain_results();
    load_regs(ttempo_pkg::MIN_GAP_RST, ttempo_pkg::MAX_GAP_RST,
              ttempo_pkg::P_FLOOR_RST, ttempo_pkg::P_CEILING_RST);
    tap_phase(150, 1'b0);
    drain_results();

    if (mismatches == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls, calm stretches, and one long hold on request
  // ---------------------------------------------------------------------------
  initial begin : result_side
    int unsigned n, turns;
    bit          rx_busy;
    out_stall = 1'b0;
    rx_busy   = 1'b1;
    turns     = 0;
    @(posedge clk);
    forever begin
      if (turns % 64 == 0) rx_busy = ($urandom_range(0, 3) != 0);
      turns++;
      if (hold_results) begin
        hold_results = 1'b0;
        n = LONG_HOLD;
      end else begin
        n = idle_len(rx_busy);
      end
      if (n == 0) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  // each accepted result is checked against the oldest owed one
  always @(posedge clk) begin : result_check
    tempo_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_periods.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result valid=%0d period=%0d held=%0d",
                 $time, period_valid, period_us, taps_held);
      end else begin
        want = due_periods.pop_front();
        if (period_valid !== want.valid) begin
          mismatches++;
          $display("%0t: period_valid expected %0d got %0d",
                   $time, want.valid, period_valid);
        end
        if (period_us !== want.period) begin
          mismatches++;
          $display("%0t: period_us expected %0d got %0d",
                   $time, want.period, period_us);
        end
        if (taps_held !== want.held) begin
          mismatches++;
          $display("%0t: taps_held expected %0d got %0d",
                   $time, want.held, taps_held);
        end
      end
    end
  end

  initial begin : watchdog
    #TIMEOUT;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
